// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the min/max bucket decimator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property, disabled while reset is asserted.
`define MMBD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked in the cycle after the antecedent.
`define MMBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/mmbd_pkg.sv -----
// Package for the min/max bucket decimator: widths, register indexes, types.
// No dependencies; imported by every module of the block.
package mmbd_pkg;

    localparam int MAX_WINDOW_DEF  = 65536;
    localparam int MAX_BUCKETS_DEF = 4096;

    localparam int TIME_W     = 32;
    localparam int VALUE_W    = 32;
    localparam int BCOUNT_W   = 13;
    localparam int WSAMP_W    = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;
    localparam int DATA_W     = TIME_W + VALUE_W;
    localparam int MAX_RES    = 3;
    localparam int RES_CNT_W  = 2;
    localparam int NUM_CAND   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_BUCKETS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SAMPLES = 1'b1;

    typedef struct packed {
        logic        [TIME_W-1:0]  time_word;
        logic signed [VALUE_W-1:0] value;
    } t_vertex;

    typedef struct packed {
        t_vertex vtx;
        logic    run_last;
        logic    window_done;
    } t_result;

    typedef struct packed {
        logic [RES_CNT_W-1:0]        count;
        t_result [MAX_RES-1:0]       slot;
    } t_result_set;

endpackage

// ----- hdl/mmbd_core.sv -----
// Per-sample decimation logic and window/bucket state for the decimator.
// Depends on mmbd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mmbd_core import mmbd_pkg::*; #(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int WW          = $clog2(MAX_WINDOW + 1),
    parameter int BW          = $clog2(MAX_BUCKETS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_restart,
    input  logic          i_fire,
    input  logic [BW-1:0] i_num_buckets,
    input  logic [WW-1:0] i_window,
    input  t_vertex       i_vtx,
    output t_result_set   o_set
);

    localparam int SW = WW + BW;

    logic [WW-1:0] r_pos;
    logic [SW-1:0] r_scaled;
    logic [SW-1:0] r_edge;
    t_vertex       r_min;
    t_vertex       r_max;
    logic          r_min_first;
    logic          r_open;
    t_vertex       r_prev;
    logic          r_prev_valid;

    t_vertex       n_min;
    t_vertex       n_max;
    logic          n_min_first;
    logic [SW-1:0] n_scaled;
    logic [SW-1:0] n_edge;
    logic          n_open;
    t_vertex       n_prev;
    logic          n_prev_valid;

    logic          win_zero;
    logic          pass;
    logic          last;
    logic          first;
    logic          close;
    logic [SW:0]   close_sum;
    logic [NUM_CAND-1:0] c_en;
    t_vertex       c_vtx [NUM_CAND];
    logic [NUM_CAND-1:0] keep;
    logic [2:0]    k;
    logic          dup;

    assign win_zero = (i_window == '0);
    assign pass     = (i_num_buckets == '0)
                   || (SW'(i_window) <= (SW'(i_num_buckets) << 1));
    assign last     = ((WW+1)'(r_pos) + (WW+1)'(1)) >= (WW+1)'(i_window);
    assign first    = (r_pos == '0);

    always_comb begin
        // bucket min/max tracking; earliest sample wins on ties
        n_min       = r_min;
        n_max       = r_max;
        n_min_first = r_min_first;
        if (!r_open) begin
            n_min       = i_vtx;
            n_max       = i_vtx;
            n_min_first = 1'b1;
        end else if (i_vtx.value < r_min.value) begin
            n_min       = i_vtx;
            n_min_first = 1'b0;
        end else if (i_vtx.value > r_max.value) begin
            n_max       = i_vtx;
            n_min_first = 1'b1;
        end

        n_scaled  = r_scaled + SW'(i_num_buckets);
        close_sum = (SW+1)'(n_scaled) + (SW+1)'(i_num_buckets);
        close     = close_sum > (SW+1)'(r_edge);
        n_edge    = close ? (r_edge + SW'(i_window)) : r_edge;
        n_open    = !close;

        // emission candidates in order: first sample, bucket pair, last sample
        c_en[0]  = first;
        c_vtx[0] = i_vtx;
        c_en[1]  = close;
        c_vtx[1] = n_min_first ? n_min : n_max;
        c_en[2]  = close && (n_min.value != n_max.value);
        c_vtx[2] = n_min_first ? n_max : n_min;
        if (n_min.value == n_max.value) begin
            c_vtx[1] = n_min;
        end
        c_en[3]  = last;
        c_vtx[3] = i_vtx;

        // dedupe chain against the previous emission of this window
        n_prev       = r_prev;
        n_prev_valid = first ? 1'b0 : r_prev_valid;
        for (int i = 0; i < NUM_CAND; i++) begin
            dup     = n_prev_valid && (n_prev == c_vtx[i]);
            keep[i] = c_en[i] && !dup;
            if (keep[i]) begin
                n_prev       = c_vtx[i];
                n_prev_valid = 1'b1;
            end
        end

        k     = '0;
        o_set = '0;
        if (win_zero) begin
            o_set.count = '0;
        end else if (pass) begin
            o_set.count            = RES_CNT_W'(1);
            o_set.slot[0].vtx      = i_vtx;
        end else begin
            for (int i = 0; i < NUM_CAND; i++) begin
                if (keep[i] && (k < 3'(MAX_RES))) begin
                    o_set.slot[k[1:0]].vtx = c_vtx[i];
                    k = k + 3'd1;
                end
            end
            o_set.count = k[RES_CNT_W-1:0];
        end
        for (int j = 0; j < MAX_RES; j++) begin
            o_set.slot[j].run_last    = (o_set.count != '0)
                                     && (RES_CNT_W'(j) == o_set.count - RES_CNT_W'(1));
            o_set.slot[j].window_done = last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_scaled     <= '0;
            r_edge       <= '0;
            r_min        <= '0;
            r_max        <= '0;
            r_min_first  <= 1'b1;
            r_open       <= 1'b0;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
        end else if (i_restart || (i_fire && !win_zero && last)) begin
            r_pos        <= '0;
            r_scaled     <= '0;
            r_edge       <= SW'(i_window);
            r_min        <= '0;
            r_max        <= '0;
            r_min_first  <= 1'b1;
            r_open       <= 1'b0;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
        end else if (i_fire && !win_zero) begin
            r_pos <= r_pos + WW'(1);
            if (!pass) begin
                r_min        <= n_min;
                r_max        <= n_max;
                r_min_first  <= n_min_first;
                r_scaled     <= n_scaled;
                r_edge       <= n_edge;
                r_open       <= n_open;
                r_prev       <= n_prev;
                r_prev_valid <= n_prev_valid;
            end
        end
    end

    `MMBD_ASSERT(a_open_mid_window, i_clk, i_rst_n, r_open |-> (r_pos != '0), "bucket open at window start")
    `MMBD_ASSERT_NEXT(a_restart_clears, i_clk, i_rst_n, i_restart, (r_pos == '0) && !r_open, "restart did not clear window")

endmodule

// ----- hdl/mmbd_out_buf.sv -----
// Result buffer: holds the up-to-three results of one sample and drains them
// one per cycle onto the output stream while m_axis_tready is high; depends on mmbd_pkg, assert_macros.svh.
`include "assert_macros.svh"

module mmbd_out_buf import mmbd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_result_set       i_set,
    output logic              o_can_load,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // out_time_word, out_value
    output logic              m_axis_tlast,   // run_last
    output logic              m_axis_tuser    // window_done
);

    t_result              r_slot [MAX_RES];
    logic [RES_CNT_W-1:0] r_cnt;
    logic                 pop;

    assign pop        = (r_cnt != '0) && m_axis_tready;
    assign o_can_load = (r_cnt == '0) || ((r_cnt == RES_CNT_W'(1)) && pop);

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = {r_slot[0].vtx.value, r_slot[0].vtx.time_word};
    assign m_axis_tlast  = r_slot[0].run_last;
    assign m_axis_tuser  = r_slot[0].window_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_set.count;
        end else if (pop) begin
            r_cnt <= r_cnt - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < MAX_RES; i++) begin
                r_slot[i] <= i_set.slot[i];
            end
        end else if (pop) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                r_slot[i] <= r_slot[i+1];
            end
        end
    end

    `MMBD_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= RES_CNT_W'(MAX_RES), "result count overflow")
    `MMBD_ASSERT_NEXT(a_drain_rest, i_clk, i_rst_n, pop && (r_cnt > RES_CNT_W'(1)), r_cnt != '0, "results lost while draining")

endmodule

// ----- hdl/min_max_bucket_decimator_unit.sv -----
// Min/max bucket decimator: top level with config registers and input stage.
// Depends on mmbd_pkg, mmbd_core and mmbd_out_buf.
//
// Usage:
//  - Config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data):
//    index 0 = number of buckets, index 1 = samples per window. Values above
//    MAX_BUCKETS / MAX_WINDOW saturate (buckets from the low 13 bits). A write
//    restarts the window; write only while the block is idle. o_cfg_ready is always high.
//  - Input stream s_axis: one time-stamped sample per request.
//  - Output stream m_axis: emitted vertices; tlast marks the last result
//    caused by a sample, tuser marks results of the window's final sample.
//  - Path: a sample goes from the input register through the core into the
//    result buffer, whose output drives m_axis; a full buffer can hold it back.
//  - Throughput: one sample per cycle while each yields at most one result and
//    m_axis_tready stays high; a sample yielding n results (up to 3) holds the output port until all n drain.
//  - Reset (i_rst_n low, synchronous): both registers 0, so samples are
//    dropped until window_samples is written; window state and output cleared.
//  - Receiver stall: results wait in the buffer; the input register still
//    takes one more sample, then s_axis_tready drops until space frees.
module min_max_bucket_decimator_unit import mmbd_pkg::*; #(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [DATA_W-1:0]     s_axis_tdata,   // time_word, sample_value
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [DATA_W-1:0]     m_axis_tdata,   // out_time_word, out_value
    output logic                  m_axis_tlast,   // run_last
    output logic                  m_axis_tuser    // window_done
);

    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam int BW = $clog2(MAX_BUCKETS + 1);

    logic [BW-1:0] r_num_buckets;
    logic [WW-1:0] r_window;
    logic          r_cfg_restart;
    logic          r_in_valid;
    t_vertex       r_in_vtx;

    logic          cfg_wr;
    logic [31:0]   bc_raw;
    logic [31:0]   ws_raw;
    logic          fire;
    logic          can_load;
    t_result_set   res_set;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign bc_raw      = 32'(i_cfg_data[BCOUNT_W-1:0]);
    assign ws_raw      = 32'(i_cfg_data[WSAMP_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_buckets <= '0;
            r_window      <= '0;
            r_cfg_restart <= 1'b0;
        end else begin
            r_cfg_restart <= cfg_wr;
            if (cfg_wr) begin
                case (i_cfg_index)
                    REG_NUM_BUCKETS: begin
                        r_num_buckets <= (bc_raw > 32'(MAX_BUCKETS)) ? BW'(MAX_BUCKETS)
                                                                     : BW'(bc_raw);
                    end
                    REG_WINDOW_SAMPLES: begin
                        r_window      <= (ws_raw > 32'(MAX_WINDOW)) ? WW'(MAX_WINDOW)
                                                                    : WW'(ws_raw);
                    end
                    default: begin
                        r_window      <= r_window;
                    end
                endcase
            end
        end
    end

    // input register; it drains into the core when the result buffer frees
    assign fire          = r_in_valid && can_load;
    assign s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_vtx.time_word <= s_axis_tdata[TIME_W-1:0];
            r_in_vtx.value     <= s_axis_tdata[DATA_W-1:TIME_W];
        end
    end

    mmbd_core #(
        .MAX_WINDOW  (MAX_WINDOW),
        .MAX_BUCKETS (MAX_BUCKETS),
        .WW          (WW),
        .BW          (BW)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_restart      (r_cfg_restart),
        .i_fire         (fire),
        .i_num_buckets  (r_num_buckets),
        .i_window       (r_window),
        .i_vtx          (r_in_vtx),
        .o_set          (res_set)
    );

    mmbd_out_buf u_out_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (fire),
        .i_set         (res_set),
        .o_can_load    (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
